@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/irclp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclp_pkg
// Shared types, codes and match tables of the IRC line parser.
// ----------------------------------------------------------------------------
package irclp_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int RFIFO_DEPTH     = 4;
  localparam int RFIFO_AW        = $clog2(RFIFO_DEPTH);

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_USER    = 2'd1;
  localparam logic [1:0] KIND_CONTENT = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [1:0] MSG_IGNORED = 2'd0;
  localparam logic [1:0] MSG_PRIVMSG = 2'd1;
  localparam logic [1:0] MSG_PING    = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  msg_type;
    logic        is_subscriber;
    logic [15:0] line_length;
    logic        last;
  } result_t;

  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } result_pair_t;

  // "badges="
  function automatic logic [7:0] key_char(input logic [2:0] i);
    case (i)
      3'd0:    key_char = "b";
      3'd1:    key_char = "a";
      3'd2:    key_char = "d";
      3'd3:    key_char = "g";
      3'd4:    key_char = "e";
      3'd5:    key_char = "s";
      3'd6:    key_char = "=";
      default: key_char = 8'h00;
    endcase
  endfunction

  // "subscriber"
  function automatic logic [7:0] sub_char(input logic [3:0] i);
    case (i)
      4'd0:    sub_char = "s";
      4'd1:    sub_char = "u";
      4'd2:    sub_char = "b";
      4'd3:    sub_char = "s";
      4'd4:    sub_char = "c";
      4'd5:    sub_char = "r";
      4'd6:    sub_char = "i";
      4'd7:    sub_char = "b";
      4'd8:    sub_char = "e";
      4'd9:    sub_char = "r";
      default: sub_char = 8'h00;
    endcase
  endfunction

  // "PRIVMSG"
  function automatic logic [7:0] priv_char(input logic [2:0] i);
    case (i)
      3'd0:    priv_char = "P";
      3'd1:    priv_char = "R";
      3'd2:    priv_char = "I";
      3'd3:    priv_char = "V";
      3'd4:    priv_char = "M";
      3'd5:    priv_char = "S";
      3'd6:    priv_char = "G";
      default: priv_char = 8'h00;
    endcase
  endfunction

  // "PING :"
  function automatic logic [7:0] ping_char(input logic [2:0] i);
    case (i)
      3'd0:    ping_char = "P";
      3'd1:    ping_char = "I";
      3'd2:    ping_char = "N";
      3'd3:    ping_char = "G";
      3'd4:    ping_char = " ";
      3'd5:    ping_char = ":";
      default: ping_char = 8'h00;
    endcase
  endfunction

endpackage

@@ hdl/irclp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclp_parser
// Per-line parse state; turns one byte into one or two result records.
// ----------------------------------------------------------------------------
module irclp_parser #(
  parameter int LENGTH_BITS = irclp_pkg::LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            data_byte,
  output irclp_pkg::result_pair_t res
);
  import irclp_pkg::*;

  typedef enum logic [11:0] {
    PH_START      = 12'b000000000001,
    PH_TAGS       = 12'b000000000010,
    PH_AFTER_TAGS = 12'b000000000100,
    PH_USER       = 12'b000000001000,
    PH_PFX_SKIP   = 12'b000000010000,
    PH_CMD_FIRST  = 12'b000000100000,
    PH_CMD_P      = 12'b000001000000,
    PH_CMD_PRIV   = 12'b000010000000,
    PH_CMD_PING   = 12'b000100000000,
    PH_SKIP       = 12'b001000000000,
    PH_PRIV_WAIT  = 12'b010000000000,
    PH_CONTENT    = 12'b100000000000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [2:0]             badge_key_match, badge_key_match_next;
  logic                   badge_seen, badge_seen_next;
  logic                   in_badge_value, in_badge_value_next;
  logic [3:0]             sub_word_match, sub_word_match_next;
  logic                   subscriber_flag, subscriber_flag_next;
  logic [2:0]             command_match, command_match_next;
  logic [1:0]             message_kind, message_kind_next;
  logic                   pending_cr, pending_cr_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic [LENGTH_BITS-1:0] count_inc;

  logic                   do_body, do_tag, ended, em_cr, em_main;
  logic [1:0]             main_kind;
  logic [15:0]            len16;
  result_t                rec_cr, rec_main, rec_end, rec_none;

  assign count_inc = (byte_count != '1) ? byte_count + LENGTH_BITS'(1) : byte_count;

  always_comb begin
    phase_t     bph;
    logic [3:0] ms;
    logic [2:0] mk;
    phase_next           = phase;
    badge_key_match_next = badge_key_match;
    badge_seen_next      = badge_seen;
    in_badge_value_next  = in_badge_value;
    sub_word_match_next  = sub_word_match;
    subscriber_flag_next = subscriber_flag;
    command_match_next   = command_match;
    message_kind_next    = message_kind;
    pending_cr_next      = pending_cr;
    do_body   = 1'b0;
    do_tag    = 1'b0;
    ended     = 1'b0;
    em_cr     = 1'b0;
    em_main   = 1'b0;
    main_kind = KIND_NONE;
    ms        = '0;
    mk        = '0;

    byte_count_next = count_inc;

    case (phase)
      PH_START: begin
        if (data_byte == CH_AT) phase_next = PH_TAGS;
        else if (data_byte == CH_COLON) phase_next = PH_USER;
        else begin
          phase_next = PH_CMD_FIRST;
          do_body    = 1'b1;
        end
      end
      PH_TAGS: begin
        if (data_byte == CH_SPACE) phase_next = PH_AFTER_TAGS;
        else do_tag = 1'b1;
      end
      PH_AFTER_TAGS: begin
        if (data_byte == CH_COLON) phase_next = PH_USER;
        else begin
          phase_next = PH_CMD_FIRST;
          do_body    = 1'b1;
        end
      end
      PH_USER: begin
        if (data_byte == CH_BANG) phase_next = PH_PFX_SKIP;
        else if (data_byte == CH_SPACE) phase_next = PH_CMD_FIRST;
        else begin
          em_main   = 1'b1;
          main_kind = KIND_USER;
        end
      end
      PH_PFX_SKIP: begin
        if (data_byte == CH_SPACE) phase_next = PH_CMD_FIRST;
      end
      PH_CMD_FIRST, PH_CMD_P, PH_CMD_PRIV, PH_CMD_PING,
      PH_SKIP, PH_PRIV_WAIT, PH_CONTENT: begin
        do_body = 1'b1;
      end
      default: phase_next = PH_START;
    endcase

    // tag section: badges key and subscriber word search
    if (do_tag) begin
      if (in_badge_value) begin
        if (data_byte == CH_SEMI) in_badge_value_next = 1'b0;
        else if (!subscriber_flag) begin
          ms = (sub_word_match > 4'd9) ? 4'd0 : sub_word_match;
          if (data_byte == sub_char(ms)) ms = ms + 4'd1;
          else if (ms == 4'd4 && data_byte == "u") ms = 4'd2;
          else ms = (data_byte == "s") ? 4'd1 : 4'd0;
          if (ms == 4'd10) begin
            subscriber_flag_next = 1'b1;
            ms = 4'd0;
          end
          sub_word_match_next = ms;
        end
      end else if (!badge_seen) begin
        mk = (badge_key_match > 3'd6) ? 3'd0 : badge_key_match;
        if (data_byte == key_char(mk)) mk = mk + 3'd1;
        else mk = (data_byte == "b") ? 3'd1 : 3'd0;
        if (mk == 3'd7) begin
          badge_seen_next     = 1'b1;
          in_badge_value_next = 1'b1;
          mk = 3'd0;
        end
        badge_key_match_next = mk;
      end
    end

    // command and content part
    bph = phase_next;
    if (do_body) begin
      if (pending_cr) begin
        if (data_byte == CH_LF) ended = 1'b1;
        else begin
          pending_cr_next = 1'b0;
          if (bph == PH_CONTENT) em_cr = 1'b1;
        end
      end
      if (!ended) begin
        if (data_byte == CH_CR) begin
          pending_cr_next = 1'b1;
          if (!(bph inside {PH_CONTENT, PH_PRIV_WAIT})) phase_next = PH_SKIP;
        end else begin
          case (bph)
            PH_CMD_FIRST: phase_next = (data_byte == "P") ? PH_CMD_P : PH_SKIP;
            PH_CMD_P: begin
              if (data_byte == "R") begin
                phase_next         = PH_CMD_PRIV;
                command_match_next = 3'd2;
              end else if (data_byte == "I") begin
                phase_next         = PH_CMD_PING;
                command_match_next = 3'd2;
              end else phase_next = PH_SKIP;
            end
            PH_CMD_PRIV: begin
              if (command_match < 3'd7 && data_byte == priv_char(command_match)) begin
                command_match_next = command_match + 3'd1;
                if (command_match == 3'd6) begin
                  phase_next        = PH_PRIV_WAIT;
                  message_kind_next = MSG_PRIVMSG;
                end
              end else phase_next = PH_SKIP;
            end
            PH_CMD_PING: begin
              if (command_match < 3'd6 && data_byte == ping_char(command_match)) begin
                command_match_next = command_match + 3'd1;
                if (command_match == 3'd5) begin
                  phase_next        = PH_CONTENT;
                  message_kind_next = MSG_PING;
                end
              end else phase_next = PH_SKIP;
            end
            PH_PRIV_WAIT: begin
              if (data_byte == CH_COLON) phase_next = PH_CONTENT;
            end
            PH_CONTENT: begin
              em_main   = 1'b1;
              main_kind = KIND_CONTENT;
            end
            default: ;
          endcase
        end
      end
    end

    // end of line: back to the start-of-line state
    if (ended) begin
      phase_next           = PH_START;
      badge_key_match_next = '0;
      badge_seen_next      = 1'b0;
      in_badge_value_next  = 1'b0;
      sub_word_match_next  = '0;
      subscriber_flag_next = 1'b0;
      command_match_next   = '0;
      message_kind_next    = MSG_IGNORED;
      pending_cr_next      = 1'b0;
      byte_count_next      = '0;
    end
  end

  assign len16 = (32'(count_inc) > 32'(16'hFFFF)) ? 16'hFFFF : 16'(count_inc);

  always_comb begin
    rec_none = '0;
    rec_cr   = '0;
    rec_cr.kind     = KIND_CONTENT;
    rec_cr.out_byte = CH_CR;
    rec_main = '0;
    rec_main.kind     = main_kind;
    rec_main.out_byte = data_byte;
    rec_end = '0;
    rec_end.kind          = KIND_END;
    rec_end.msg_type      = message_kind;
    rec_end.is_subscriber = subscriber_flag;
    // line length uses the count before the end-of-line clear
    rec_end.line_length   = len16;

    res.two = em_cr && em_main;
    if (em_cr)        res.r0 = rec_cr;
    else if (em_main) res.r0 = rec_main;
    else if (ended)   res.r0 = rec_end;
    else              res.r0 = rec_none;
    res.r0.last = !(em_cr && em_main);
    res.r1      = rec_main;
    res.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      badge_key_match <= '0;
      badge_seen      <= 1'b0;
      in_badge_value  <= 1'b0;
      sub_word_match  <= '0;
      subscriber_flag <= 1'b0;
      command_match   <= '0;
      message_kind    <= MSG_IGNORED;
      pending_cr      <= 1'b0;
      byte_count      <= '0;
    end else if (en) begin
      phase           <= phase_next;
      badge_key_match <= badge_key_match_next;
      badge_seen      <= badge_seen_next;
      in_badge_value  <= in_badge_value_next;
      sub_word_match  <= sub_word_match_next;
      subscriber_flag <= subscriber_flag_next;
      command_match   <= command_match_next;
      message_kind    <= message_kind_next;
      pending_cr      <= pending_cr_next;
      byte_count      <= byte_count_next;
    end
  end

endmodule

@@ hdl/irclp_rfifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclp_rfifo
// Small result queue; takes one or two records a cycle, gives one.
// ----------------------------------------------------------------------------
module irclp_rfifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  irclp_pkg::result_pair_t din,
  input  logic                    pop,
  output irclp_pkg::result_t      head,
  output logic                    not_empty,
  output logic                    room2
);
  import irclp_pkg::*;

  result_t              slots [RFIFO_DEPTH];
  logic [RFIFO_AW-1:0]  wptr, rptr;
  logic [RFIFO_AW:0]    count;
  logic [RFIFO_AW:0]    n_push;

  assign n_push    = push ? (din.two ? (RFIFO_AW+1)'(2) : (RFIFO_AW+1)'(1)) : '0;
  assign head      = slots[rptr];
  assign not_empty = (count != '0);
  assign room2     = (count <= (RFIFO_AW+1)'(RFIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din.r0;
      if (din.two) slots[wptr + RFIFO_AW'(1)] <= din.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push[RFIFO_AW-1:0];
      rptr  <= rptr + RFIFO_AW'(pop);
      count <= count + n_push - (RFIFO_AW+1)'(pop);
    end
  end

endmodule

@@ hdl/irc_line_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_parser_top
// IRC line parser: one text byte in, user/content/end records out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_stall | data_byte
//  out     | output    | out_valid/out_stall | kind, out_byte, msg_type,
//          |           |                     | is_subscriber, line_length, last
//
// One byte per cycle sustained while in_stall stays low: a registered byte is parsed
// into a four-word result queue. A byte other than CR or LF after a held CR in
// content gives two words, so such a byte takes two queue slots.
// Synchronous reset returns the parser to start of line and empties the queue.
// in_stall rises while a byte is held and the queue has fewer than two free slots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irc_line_parser_top #(
  parameter int LENGTH_BITS = irclp_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  msg_type,
  output logic        is_subscriber,
  output logic [15:0] line_length,
  output logic        last
);
  import irclp_pkg::*;

  logic         in_full;
  logic [7:0]   in_byte;
  logic         process, room2, not_empty, pop, in_acc;
  result_pair_t res;
  result_t      head;

  assign process  = in_full && room2;
  assign in_stall = in_full && !room2;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) in_full <= 1'b0;
    else     in_full <= in_acc || (in_full && !process);
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_byte <= data_byte;
  end

  irclp_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (process),
    .data_byte (in_byte),
    .res       (res)
  );

  irclp_rfifo u_rfifo (
    .clk       (clk),
    .rst       (rst),
    .push      (process),
    .din       (res),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign out_valid     = not_empty;
  assign pop           = not_empty && !out_stall;
  assign kind          = head.kind;
  assign out_byte      = head.out_byte;
  assign msg_type      = head.msg_type;
  assign is_subscriber = head.is_subscriber;
  assign line_length   = head.line_length;
  assign last          = head.last;

  `ASSERT_IMPL(a_stall_only_when_held, in_stall, in_full)
  `ASSERT_IMPL(a_pair_starts_with_cr, process && res.two,
               res.r0.kind == KIND_CONTENT && res.r0.out_byte == CH_CR && !res.r0.last)
  `ASSERT_IMPL(a_end_is_last, out_valid && kind == KIND_END, last)
  `ASSERT_NEXT(a_process_fills_queue, process, out_valid)

endmodule
